/* hw/rtl/mandelbrot_escape_colorizer_top_macros.svh */
// Assertion macros shared by the modules of the escape-time colorizer.
// Each macro checks a property on the rising edge of the given clock and is
// disabled while the given reset is high.
`ifndef MANDELBROT_ESCAPE_COLORIZER_TOP_MACROS_SVH
`define MANDELBROT_ESCAPE_COLORIZER_TOP_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication.
`define MEC_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mec assertion failed");
// Next-cycle implication.
`define MEC_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mec assertion failed");
`else
`define MEC_ASSERT_IMP(label, clk, rst, ante, cons)
`define MEC_ASSERT_NXT(label, clk, rst, ante, cons)
`endif

`endif

/* hw/rtl/mec_pkg.sv */
package mec_pkg;

  localparam int FRAC_BITS  = 28;
  localparam int COUNT_BITS = 12;

  // Fixed field widths.
  localparam int CFG_W   = 32;
  localparam int STEP_W  = 28;
  localparam int SIZE_W  = 13;
  localparam int PIX_W   = 12;
  localparam int CH_W    = 8;
  localparam int ESC_W   = 12;
  localparam int LIM_F_W = 12;
  localparam int CH_MAX  = 255;

  // Coordinate set-up: products of size or pixel by step, and the point c.
  localparam int SPAN_W = SIZE_W + STEP_W;
  localparam int C_W    = SPAN_W + 2;

  // Iteration datapath.
  localparam int A_W   = FRAC_BITS + 2;
  localparam int MAG_W = FRAC_BITS + 1;
  localparam int P_W   = 2 * MAG_W;
  localparam int SQ_W  = FRAC_BITS + 2;
  localparam int AB_W  = FRAC_BITS + 3;
  localparam int Z_W   = ((C_W > FRAC_BITS + 3) ? C_W : FRAC_BITS + 3) + 2;

  // Coloring: hue position and the shared divider.
  localparam int N_W    = COUNT_BITS + 3;
  localparam int NS_W   = N_W + 1;
  localparam int NUM_W  = COUNT_BITS + 9;
  localparam int DEN_W  = COUNT_BITS + 1;
  localparam int DCNT_W = $clog2(NUM_W + 1);

  typedef logic [2:0] cfg_idx_t;
  localparam cfg_idx_t CFG_CENTER_RE = 3'd0;
  localparam cfg_idx_t CFG_CENTER_IM = 3'd1;
  localparam cfg_idx_t CFG_STEP      = 3'd2;
  localparam cfg_idx_t CFG_LIMIT     = 3'd3;
  localparam cfg_idx_t CFG_SCHEME    = 3'd4;
  localparam cfg_idx_t CFG_WIDTH     = 3'd5;
  localparam cfg_idx_t CFG_HEIGHT    = 3'd6;

  typedef logic [2:0] scheme_t;
  localparam scheme_t SCHEME_RAINBOW = 3'd0;
  localparam scheme_t SCHEME_HUE180  = 3'd1;
  localparam scheme_t SCHEME_HUE240  = 3'd2;
  localparam scheme_t SCHEME_HUE60   = 3'd3;
  localparam scheme_t SCHEME_GRAY    = 3'd4;
  localparam scheme_t SCHEME_WHITE   = 3'd5;

  typedef enum logic [1:0] {
    DIV_SECTOR,
    DIV_RAMP,
    DIV_GRAY
  } div_sel_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SETUP_MUL,
    S_SETUP_SUM,
    S_ITER_ADD,
    S_ITER_MUL,
    S_HUE_PREP,
    S_DIV_SECTOR,
    S_WAIT_SECTOR,
    S_DIV_RAMP,
    S_WAIT_RAMP,
    S_DIV_GRAY,
    S_WAIT_GRAY,
    S_FINISH
  } ctrl_state_t;

  typedef struct packed {
    logic     load_pixel;
    logic     setup_mul;
    logic     setup_sum;
    logic     iter_add;
    logic     iter_mul;
    logic     hue_prep;
    logic     div_start;
    div_sel_t div_sel;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic sum_esc;
    logic mag_esc;
    logic lim_hit;
    logic hue_mode;
    logic gray_mode;
    logic div_busy;
  } status_t;

  // Hue offset of a scheme in sectors of 60 degrees.
  function automatic logic [2:0] hue_shift(input scheme_t s);
    logic [2:0] k;
    unique case (s)
      SCHEME_HUE180: k = 3'd3;
      SCHEME_HUE240: k = 3'd4;
      SCHEME_HUE60:  k = 3'd1;
      default:       k = 3'd0;
    endcase
    return k;
  endfunction

endpackage

/* hw/rtl/mec_intf.sv */
interface mec_pixel_if;
  logic                       valid;
  logic                       ready;
  logic [mec_pkg::PIX_W-1:0]  pixel_col;
  logic [mec_pkg::PIX_W-1:0]  pixel_row;

  modport source (output valid, output pixel_col, output pixel_row, input ready);
  modport sink (input valid, input pixel_col, input pixel_row, output ready);
endinterface

interface mec_color_if;
  logic                       valid;
  logic                       ready;
  logic [mec_pkg::CH_W-1:0]   red;
  logic [mec_pkg::CH_W-1:0]   green;
  logic [mec_pkg::CH_W-1:0]   blue;
  logic [mec_pkg::ESC_W-1:0]  escape_count;

  modport source (output valid, output red, output green, output blue,
                  output escape_count, input ready);
  modport sink (input valid, input red, input green, input blue,
                input escape_count, output ready);
endinterface

/* hw/rtl/mandelbrot_escape_colorizer_top.sv */
// Channel     Dir  Payload                                  Handshake
// pixel_in    in   pixel_col[11:0], pixel_row[11:0]         valid/ready
// color_out   out  red, green, blue[7:0], escape_count[11:0] valid/ready
// cfg         in   cfg_index[2:0], cfg_data[31:0]           cfg_we, no wait
//
// One pixel is worked on at a time. Each of the N iterations takes one
// squaring pass and one add/compare pass; after that a gray value takes one
// division and a hue two, on the one-bit-per-cycle divider. The default
// iteration limit is 340. Reset is synchronous and active high; it restores
// the default view and empties the result register. A finished result waits
// in the output register while the next pixel is taken in, so a stalled
// sink holds the block only once the following pixel is done.
module mandelbrot_escape_colorizer_top (
  input  logic                      clk,
  input  logic                      rst,
  mec_pixel_if.sink                 pixel_in,
  mec_color_if.source               color_out,
  input  logic                      cfg_we,
  input  mec_pkg::cfg_idx_t         cfg_index,
  input  logic [mec_pkg::CFG_W-1:0] cfg_data
);
  import mec_pkg::*;

  // Commands from the sequencer and status back from the datapath.
  cmd_t    cmd;
  status_t status;

  // The sequencer owns the handshakes; the datapath owns all payload.
  mec_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pixel_in.valid),
    .in_ready  (pixel_in.ready),
    .out_valid (color_out.valid),
    .out_ready (color_out.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // The datapath maps the pixel to c, iterates z, and colors the result.
  mec_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .pixel_col    (pixel_in.pixel_col),
    .pixel_row    (pixel_in.pixel_row),
    .cmd          (cmd),
    .status       (status),
    .red          (color_out.red),
    .green        (color_out.green),
    .blue         (color_out.blue),
    .escape_count (color_out.escape_count)
  );

endmodule

/* hw/rtl/mec_div.sv */
`include "mandelbrot_escape_colorizer_top_macros.svh"

// Restoring divider, one quotient bit per cycle.
module mec_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [mec_pkg::NUM_W-1:0] num,
  input  logic [mec_pkg::DEN_W-1:0] den,
  output logic                      busy,
  output logic [mec_pkg::NUM_W-1:0] quo,
  output logic [mec_pkg::DEN_W-1:0] rem
);
  import mec_pkg::*;

  logic [DEN_W-1:0]  den_q;
  logic [DCNT_W-1:0] cnt;
  logic [DEN_W:0]    trial;
  logic              ge;

  assign busy  = (cnt != '0);
  assign trial = {rem, quo[NUM_W-1]};
  assign ge    = (trial >= {1'b0, den_q});

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= DCNT_W'(NUM_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo   <= num;
      rem   <= '0;
      den_q <= den;
    end else if (busy) begin
      quo <= {quo[NUM_W-2:0], ge};
      rem <= ge ? DEN_W'(trial - {1'b0, den_q}) : DEN_W'(trial);
    end
  end

  `MEC_ASSERT_NXT(a_start_busy, clk, rst, start, busy)
  `MEC_ASSERT_IMP(a_rem_below_den, clk, rst, !busy && $past(busy), rem < den_q)

endmodule

/* hw/rtl/mec_dp.sv */
// Datapath: configuration registers, point set-up, the z iteration,
// hue and gray operands for the shared divider, and the result register.
module mec_dp (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  mec_pkg::cfg_idx_t         cfg_index,
  input  logic [mec_pkg::CFG_W-1:0] cfg_data,
  input  logic [mec_pkg::PIX_W-1:0] pixel_col,
  input  logic [mec_pkg::PIX_W-1:0] pixel_row,
  input  mec_pkg::cmd_t             cmd,
  output mec_pkg::status_t          status,
  output logic [mec_pkg::CH_W-1:0]  red,
  output logic [mec_pkg::CH_W-1:0]  green,
  output logic [mec_pkg::CH_W-1:0]  blue,
  output logic [mec_pkg::ESC_W-1:0] escape_count
);
  import mec_pkg::*;

  localparam logic signed [Z_W-1:0] TWO =
    {{(Z_W - FRAC_BITS - 2){1'b0}}, 1'b1, {(FRAC_BITS + 1){1'b0}}};
  localparam logic signed [Z_W-1:0] NEG_TWO = -TWO;

  // Configuration.
  logic signed [CFG_W-1:0] center_re;
  logic signed [CFG_W-1:0] center_im;
  logic [STEP_W-1:0]       step;
  logic [COUNT_BITS-1:0]   limit;
  scheme_t                 scheme;
  logic [SIZE_W-1:0]       img_w;
  logic [SIZE_W-1:0]       img_h;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_re <= -32'sd187904819;
      center_im <= '0;
      step      <= STEP_W'(1342177);
      limit     <= COUNT_BITS'(340);
      scheme    <= SCHEME_RAINBOW;
      img_w     <= SIZE_W'(640);
      img_h     <= SIZE_W'(480);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CENTER_RE: center_re <= cfg_data;
        CFG_CENTER_IM: center_im <= cfg_data;
        CFG_STEP:      step      <= cfg_data[STEP_W-1:0];
        CFG_LIMIT:     limit     <= COUNT_BITS'(cfg_data[LIM_F_W-1:0]);
        CFG_SCHEME:    scheme    <= cfg_data[2:0];
        CFG_WIDTH:     img_w     <= cfg_data[SIZE_W-1:0];
        CFG_HEIGHT:    img_h     <= cfg_data[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // Point set-up.
  logic [PIX_W-1:0]      col_q, row_q;
  logic [SPAN_W-1:0]     span_w, span_h, off_c, off_r;
  logic signed [C_W-1:0] cr, ci;

  always_ff @(posedge clk) begin
    if (cmd.load_pixel) begin
      col_q <= pixel_col;
      row_q <= pixel_row;
    end
    if (cmd.setup_mul) begin
      span_w <= SPAN_W'(img_w) * SPAN_W'(step);
      span_h <= SPAN_W'(img_h) * SPAN_W'(step);
      off_c  <= SPAN_W'(col_q) * SPAN_W'(step);
      off_r  <= SPAN_W'(row_q) * SPAN_W'(step);
    end
    if (cmd.setup_sum) begin
      cr <= C_W'(center_re) - C_W'(span_w >> 1) + C_W'(off_c);
      ci <= C_W'(center_im) - C_W'(span_h >> 1) + C_W'(off_r);
    end
  end

  // Iteration.
  logic signed [A_W-1:0]  a, b;
  logic [SQ_W-1:0]        sa, sb;
  logic signed [AB_W-1:0] ab;
  logic [COUNT_BITS-1:0]  count;
  logic [SQ_W:0]          sum_sq;
  logic signed [Z_W-1:0]  nr, ni;
  logic                   sum_esc, mag_esc, lim_hit;
  logic [MAG_W-1:0]       ma, mb;
  logic [P_W-1:0]         pa, pb, pab;
  logic [SQ_W-1:0]        ab_mag;

  assign sum_sq  = (SQ_W + 1)'(sa) + (SQ_W + 1)'(sb);
  assign sum_esc = sum_sq[SQ_W];
  assign nr      = Z_W'(sa) - Z_W'(sb) + Z_W'(cr);
  assign ni      = (Z_W'(ab) <<< 1) + Z_W'(ci);
  assign mag_esc = (nr >= TWO) || (nr <= NEG_TWO) || (ni >= TWO) || (ni <= NEG_TWO);
  assign lim_hit = (count == limit);

  assign ma     = a[A_W-1] ? MAG_W'(-a) : MAG_W'(a);
  assign mb     = b[A_W-1] ? MAG_W'(-b) : MAG_W'(b);
  assign pa     = P_W'(ma) * P_W'(ma);
  assign pb     = P_W'(mb) * P_W'(mb);
  assign pab    = P_W'(ma) * P_W'(mb);
  assign ab_mag = SQ_W'(pab >> FRAC_BITS);

  always_ff @(posedge clk) begin
    if (cmd.setup_sum) begin
      sa    <= '0;
      sb    <= '0;
      ab    <= '0;
      count <= '0;
    end else if (cmd.iter_add && !sum_esc) begin
      if (lim_hit) begin
        count <= '0;
      end else begin
        count <= count + 1'b1;
        a     <= nr[A_W-1:0];
        b     <= ni[A_W-1:0];
      end
    end else if (cmd.iter_mul) begin
      sa <= SQ_W'(pa >> FRAC_BITS);
      sb <= SQ_W'(pb >> FRAC_BITS);
      ab <= (a[A_W-1] ^ b[A_W-1]) ? -AB_W'(ab_mag) : AB_W'(ab_mag);
    end
  end

  // Hue position n = (6*count + k*limit) mod (6*limit); one subtract suffices.
  logic [NS_W-1:0] n_sum, six_l;
  logic [N_W-1:0]  n_reg;
  logic [2:0]      sector;

  assign n_sum = NS_W'(count) * NS_W'(6) + NS_W'(hue_shift(scheme)) * NS_W'(limit);
  assign six_l = NS_W'(limit) * NS_W'(6);

  // Shared divider.
  logic [NUM_W-1:0] div_num, div_quo;
  logic [DEN_W-1:0] div_den, div_rem;
  logic             div_busy;

  always_comb begin
    unique case (cmd.div_sel)
      DIV_SECTOR: begin
        div_num = NUM_W'(n_reg);
        div_den = DEN_W'(limit);
      end
      DIV_RAMP: begin
        div_num = NUM_W'(div_rem) * NUM_W'(CH_MAX);
        div_den = DEN_W'(limit);
      end
      DIV_GRAY: begin
        div_num = NUM_W'(count) * NUM_W'(2 * CH_MAX) + NUM_W'(limit);
        div_den = DEN_W'(limit) << 1;
      end
      default: begin
        div_num = '0;
        div_den = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.hue_prep) begin
      n_reg <= N_W'((n_sum >= six_l) ? n_sum - six_l : n_sum);
    end
    if (cmd.div_start && cmd.div_sel == DIV_RAMP) begin
      sector <= div_quo[2:0];
    end
  end

  mec_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .quo   (div_quo),
    .rem   (div_rem)
  );

  // Color.
  logic [CH_W-1:0] up, down, r_c, g_c, b_c;

  assign up   = div_quo[CH_W-1:0];
  assign down = CH_W'(CH_MAX) - up - CH_W'(div_rem != '0);

  always_comb begin
    r_c = '0;
    g_c = '0;
    b_c = '0;
    if (count != '0) begin
      priority if (scheme <= SCHEME_HUE60) begin
        unique case (sector)
          3'd0: begin r_c = CH_W'(CH_MAX); g_c = up; end
          3'd1: begin r_c = down; g_c = CH_W'(CH_MAX); end
          3'd2: begin g_c = CH_W'(CH_MAX); b_c = up; end
          3'd3: begin g_c = down; b_c = CH_W'(CH_MAX); end
          3'd4: begin r_c = up; b_c = CH_W'(CH_MAX); end
          default: begin r_c = CH_W'(CH_MAX); b_c = down; end
        endcase
      end else if (scheme == SCHEME_GRAY) begin
        r_c = up;
        g_c = up;
        b_c = up;
      end else if (scheme == SCHEME_WHITE) begin
        r_c = CH_W'(CH_MAX);
        g_c = CH_W'(CH_MAX);
        b_c = CH_W'(CH_MAX);
      end else begin
        r_c = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      red          <= r_c;
      green        <= g_c;
      blue         <= b_c;
      escape_count <= ESC_W'(count);
    end
  end

  assign status.sum_esc   = sum_esc;
  assign status.mag_esc   = mag_esc;
  assign status.lim_hit   = lim_hit;
  assign status.hue_mode  = (scheme <= SCHEME_HUE60);
  assign status.gray_mode = (scheme == SCHEME_GRAY);
  assign status.div_busy  = div_busy;

endmodule

/* hw/rtl/mec_ctrl.sv */
`include "mandelbrot_escape_colorizer_top_macros.svh"

// Sequencer for one pixel at a time, plus the result valid flag.
module mec_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  mec_pkg::status_t status,
  output mec_pkg::cmd_t    cmd
);
  import mec_pkg::*;

  ctrl_state_t state, state_next;
  logic        out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    ctrl_state_t esc_next;

    state_next  = state;
    cmd         = '0;
    cmd.div_sel = DIV_SECTOR;
    in_ready    = 1'b0;

    priority if (status.hue_mode) esc_next = S_HUE_PREP;
    else if (status.gray_mode) esc_next = S_DIV_GRAY;
    else esc_next = S_FINISH;

    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_pixel = 1'b1;
          state_next     = S_SETUP_MUL;
        end
      end
      S_SETUP_MUL: begin
        cmd.setup_mul = 1'b1;
        state_next    = S_SETUP_SUM;
      end
      S_SETUP_SUM: begin
        cmd.setup_sum = 1'b1;
        state_next    = S_ITER_ADD;
      end
      S_ITER_ADD: begin
        cmd.iter_add = 1'b1;
        priority if (status.sum_esc) state_next = esc_next;
        else if (status.lim_hit) state_next = S_FINISH;
        else if (status.mag_esc) state_next = esc_next;
        else state_next = S_ITER_MUL;
      end
      S_ITER_MUL: begin
        cmd.iter_mul = 1'b1;
        state_next   = S_ITER_ADD;
      end
      S_HUE_PREP: begin
        cmd.hue_prep = 1'b1;
        state_next   = S_DIV_SECTOR;
      end
      S_DIV_SECTOR: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_SECTOR;
        state_next    = S_WAIT_SECTOR;
      end
      S_WAIT_SECTOR: begin
        if (!status.div_busy) state_next = S_DIV_RAMP;
      end
      S_DIV_RAMP: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_RAMP;
        state_next    = S_WAIT_RAMP;
      end
      S_WAIT_RAMP: begin
        if (!status.div_busy) state_next = S_FINISH;
      end
      S_DIV_GRAY: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_GRAY;
        state_next    = S_WAIT_GRAY;
      end
      S_WAIT_GRAY: begin
        if (!status.div_busy) state_next = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase

    if (cmd.out_load) out_valid_next = 1'b1;
    else if (out_ready) out_valid_next = 1'b0;
    else out_valid_next = out_valid;
  end

  `MEC_ASSERT_IMP(a_no_overwrite, clk, rst, cmd.out_load, !out_valid || out_ready)
  `MEC_ASSERT_IMP(a_div_start_idle, clk, rst, cmd.div_start, !status.div_busy)

endmodule
